// ----- rtl/pssc_pkg.sv -----
// ----------------------------------------------------------------------------
// pssc_pkg
// Shared types, constants and clamp limits for the scaled square root block.
// ----------------------------------------------------------------------------
package pssc_pkg;

  // radicand width, one pixel word
  localparam int unsigned RAD_W = 32;
  // scale factor fraction bits (Q16.16)
  localparam int unsigned SCALE_FRAC_BITS = 16;

  // configuration register indexes
  typedef enum logic {
    CFG_PIXEL_TYPE   = 1'b0,
    CFG_SCALE_FACTOR = 1'b1
  } cfg_reg_e;

  // pixel type codes, unused codes behave as signed 32-bit
  typedef enum logic [2:0] {
    PT_U8  = 3'd0,
    PT_S8  = 3'd1,
    PT_U16 = 3'd2,
    PT_S16 = 3'd3,
    PT_S32 = 3'd4
  } pix_type_e;

  // lower clamp limit of a pixel type
  function automatic logic signed [32:0] type_lo(logic [2:0] ptype);
    logic signed [32:0] lim;
    unique case (ptype)
      PT_U8:   lim = 33'sd0;
      PT_S8:   lim = -33'sd128;
      PT_U16:  lim = 33'sd0;
      PT_S16:  lim = -33'sd32768;
      default: lim = -33'sd2147483648;
    endcase
    return lim;
  endfunction

  // upper clamp limit of a pixel type
  function automatic logic signed [32:0] type_hi(logic [2:0] ptype);
    logic signed [32:0] lim;
    unique case (ptype)
      PT_U8:   lim = 33'sd255;
      PT_S8:   lim = 33'sd127;
      PT_U16:  lim = 33'sd65535;
      PT_S16:  lim = 33'sd32767;
      default: lim = 33'sd2147483647;
    endcase
    return lim;
  endfunction

endpackage

// ----- rtl/pssc_root_cell.sv -----
// ----------------------------------------------------------------------------
// pssc_root_cell
// One restoring square root step: brings in the next radicand bit pair,
// tries the trial divisor and settles one root bit, then hands on.
// ----------------------------------------------------------------------------
module pssc_root_cell
  import pssc_pkg::*;
#(
  parameter int unsigned RootW = 32,
  parameter int unsigned RemW  = 36
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // upstream side
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RemW-1:0]    rem_i,
  input  logic [RootW-1:0]   root_i,
  input  logic [RAD_W-1:0]   rad_i,
  input  logic               last_i,
  // downstream side
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RemW-1:0]    rem_o,
  output logic [RootW-1:0]   root_o,
  output logic [RAD_W-1:0]   rad_o,
  output logic               last_o
);

  logic               valid_q;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic               last_q;
  logic [RemW-1:0]    rem_sh;
  logic [RemW-1:0]    trial;
  logic               fits;

  // trial subtract for one root bit
  always_comb begin
    rem_sh = {rem_i[RemW-3:0], rad_i[RAD_W-1:RAD_W-2]};
    trial  = {{(RemW-RootW-2){1'b0}}, root_i, 2'b01};
    fits   = (rem_sh >= trial);
    rem_d  = fits ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[RootW-2:0], fits};
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
  end

  // stage can take a word when empty or when its word moves on
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      last_q <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign root_o      = root_q;
  assign rad_o       = rad_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/pssc_scale_clip.sv -----
// ----------------------------------------------------------------------------
// pssc_scale_clip
// Multiplies the root by the scale magnitude in two partial products, rounds
// half away from zero, applies the sign and clamps to the pixel type range.
// ----------------------------------------------------------------------------
module pssc_scale_clip
  import pssc_pkg::*;
#(
  parameter int unsigned RootW    = 32,
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // static configuration
  input  logic [2:0]         pixel_type_i,
  input  logic               neg_scale_i,
  input  logic [31:0]        scale_mag_i,
  // root from the cell chain
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RootW-1:0]   root_i,
  input  logic               last_i,
  // result word
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        pixel_out_o,
  output logic               clamped_o,
  output logic               last_out_o
);

  localparam int unsigned LoW   = (RootW + 1) / 2;
  localparam int unsigned HiW   = RootW - LoW;
  localparam int unsigned ProdW = RootW + 32;
  localparam int unsigned Shift = FracBits + SCALE_FRAC_BITS;
  localparam logic [ProdW-1:0] Half = ProdW'(1) << (Shift - 1);

  logic               v1_q, v2_q, v3_q;
  logic               rdy1, rdy2, rdy3;
  logic [LoW+31:0]    pl_q;
  logic [HiW+31:0]    ph_q;
  logic               last1_q, last2_q, last3_q;
  logic [ProdW-1:0]   sum;
  logic [31:0]        mag_q;
  logic signed [32:0] res;
  logic signed [32:0] lo_lim, hi_lim;
  logic [31:0]        pix_d, pix_q;
  logic               clamp_d, clamp_q;

  // ready ripples back through the three stages
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1: partial products of root halves
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      pl_q    <= root_i[LoW-1:0] * scale_mag_i;
      ph_q    <= root_i[RootW-1:LoW] * scale_mag_i;
      last1_q <= last_i;
    end
  end

  // stage 2: combine, add one half, drop fraction bits
  assign sum = (ProdW'(ph_q) << LoW) + ProdW'(pl_q) + Half;

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      mag_q   <= sum[ProdW-1:Shift];
      last2_q <= last1_q;
    end
  end

  // stage 3: sign and clamp
  always_comb begin
    lo_lim  = type_lo(pixel_type_i);
    hi_lim  = type_hi(pixel_type_i);
    res     = neg_scale_i ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    clamp_d = 1'b0;
    pix_d   = res[31:0];
    priority if (res < lo_lim) begin
      pix_d   = lo_lim[31:0];
      clamp_d = 1'b1;
    end else if (res > hi_lim) begin
      pix_d   = hi_lim[31:0];
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      pix_q   <= pix_d;
      clamp_q <= clamp_d;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign pixel_out_o = pix_q;
  assign clamped_o   = clamp_q;
  assign last_out_o  = last3_q;

endmodule

// ----- rtl/pixel_sqrt_scale_clip.sv -----
// ----------------------------------------------------------------------------
// pixel_sqrt_scale_clip
// Scaled square root per pixel with clamp to the pixel type range.
// ----------------------------------------------------------------------------
// pipeline: one register stage per root cell, then multiply, round and clamp stages
// throughput: one pixel per cycle while out_stall_i is low, set by the cell chain taking a word each cycle
// reset: clears all stage valids, pixel_type to u8 and scale_factor to 1.0
module pixel_sqrt_scale_clip
  import pssc_pkg::*;
#(
  parameter int unsigned ROOT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_in_i,
  input  logic        last_in_i,
  // pixel output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_out_o,
  output logic        clamped_o,
  output logic        last_out_o
);

  localparam int unsigned RootW    = 16 + ROOT_FRAC_BITS;
  localparam int unsigned RemW     = RootW + 4;
  localparam int unsigned NumCells = RootW;

  logic [2:0]       pixel_type_q;
  logic             neg_scale_q;
  logic [31:0]      scale_mag_q;
  logic [RAD_W-1:0] rad_in;

  logic [RemW-1:0]  rem_w   [NumCells+1];
  logic [RootW-1:0] root_w  [NumCells+1];
  logic [RAD_W-1:0] rad_w   [NumCells+1];
  logic             last_w  [NumCells+1];
  logic             valid_w [NumCells+1];
  logic             ready_w [NumCells+1];

  // configuration registers, scale kept as sign and magnitude
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_type_q <= PT_U8;
      neg_scale_q  <= 1'b0;
      scale_mag_q  <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PIXEL_TYPE: begin
          pixel_type_q <= cfg_data_i[2:0];
        end
        CFG_SCALE_FACTOR: begin
          neg_scale_q <= cfg_data_i[31];
          scale_mag_q <= cfg_data_i[31] ? (~cfg_data_i + 32'd1) : cfg_data_i;
        end
      endcase
    end
  end

  // pixel to radicand, negative values give zero
  always_comb begin
    unique case (pixel_type_q)
      PT_U8:   rad_in = {24'd0, pixel_in_i[7:0]};
      PT_S8:   rad_in = pixel_in_i[7] ? '0 : {24'd0, pixel_in_i[7:0]};
      PT_U16:  rad_in = {16'd0, pixel_in_i[15:0]};
      PT_S16:  rad_in = pixel_in_i[15] ? '0 : {16'd0, pixel_in_i[15:0]};
      default: rad_in = pixel_in_i[31] ? '0 : pixel_in_i;
    endcase
  end

  assign valid_w[0] = in_valid_i;
  assign rem_w[0]   = '0;
  assign root_w[0]  = '0;
  assign rad_w[0]   = rad_in;
  assign last_w[0]  = last_in_i;
  assign in_stall_o = !ready_w[0];

  // chain of root cells, one root bit each
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    pssc_root_cell #(
      .RootW (RootW),
      .RemW  (RemW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[c]),
      .in_ready_o  (ready_w[c]),
      .rem_i       (rem_w[c]),
      .root_i      (root_w[c]),
      .rad_i       (rad_w[c]),
      .last_i      (last_w[c]),
      .out_valid_o (valid_w[c+1]),
      .out_ready_i (ready_w[c+1]),
      .rem_o       (rem_w[c+1]),
      .root_o      (root_w[c+1]),
      .rad_o       (rad_w[c+1]),
      .last_o      (last_w[c+1])
    );
  end

  // final remainder and radicand are spent at the chain end
  pssc_scale_clip #(
    .RootW    (RootW),
    .FracBits (ROOT_FRAC_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_type_i (pixel_type_q),
    .neg_scale_i  (neg_scale_q),
    .scale_mag_i  (scale_mag_q),
    .in_valid_i   (valid_w[NumCells]),
    .in_ready_o   (ready_w[NumCells]),
    .root_i       (root_w[NumCells] | RootW'(rem_w[NumCells] & '0)
                   | RootW'(rad_w[NumCells] & '0)),
    .last_i       (last_w[NumCells]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .clamped_o    (clamped_o),
    .last_out_o   (last_out_o)
  );

`ifndef SYNTH
  // an empty output stage lets the whole chain take a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // a clamped word sits on one of the type limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamped_o) |->
      ($signed({pixel_out_o[31], pixel_out_o}) == type_lo(pixel_type_q) ||
       $signed({pixel_out_o[31], pixel_out_o}) == type_hi(pixel_type_q)))
    else $error("clamped word not at a type limit");

  // unsigned types never produce a negative word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pixel_type_q == PT_U8 || pixel_type_q == PT_U16)) |->
      !pixel_out_o[31])
    else $error("negative word for unsigned pixel type");
`endif

endmodule
